// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the cache lookup block.
// Depends on nothing; each macro expects signals named clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/salc_pkg.sv
// Package for the set-associative LRU cache lookup block.
// Holds outcome codes, register indexes and cost constants; depends on nothing.
`default_nettype none

package salc_pkg;

   typedef enum logic [1:0] {
      OUTCOME_HIT        = 2'd0,
      OUTCOME_CLEAN_MISS = 2'd1,
      OUTCOME_DIRTY_MISS = 2'd2
   } outcome_type;

   typedef enum logic [1:0] {
      CSR_SET_INDEX_BITS = 2'd0,
      CSR_OFFSET_BITS    = 2'd1,
      CSR_WAYS_IN_USE    = 2'd2
   } csr_index_type;

   localparam logic [7:0] HIT_CYCLES      = 8'd1;
   localparam logic [7:0] MISS_PENALTY    = 8'd100;
   localparam logic [3:0] MAX_OFFSET_BITS = 4'd12;

   localparam logic [3:0] RESET_SET_INDEX_BITS = 4'd0;
   localparam logic [3:0] RESET_OFFSET_BITS    = 4'd4;
   localparam logic [3:0] RESET_WAYS_IN_USE    = 4'd1;

endpackage

`default_nettype wire

// File: rtl/core/set_assoc_lru_cache_lookup.sv
// Top level of the write-back set-associative cache lookup with LRU replacement.
// Depends on salc_pkg; holds the set memory, the way scanner and the APB registers.
//
// One access is taken when start is high and busy is low. The set row is read in
// the cycle after, then a single tag comparator scans one way per cycle, then the
// row is written back. The scan covers ways_in_use ways, taken as at least 1 and
// at most MAX_WAYS. The result is on the rsp_ports for exactly one cycle with
// rsp_strobe high, starting at the edge at which busy drops, so the next access
// can be taken only once the previous one has given its result. The receiver
// cannot stall. A write to any of the three registers clears every set at once
// through a per-set valid bit, with no write-back; no clearing pass is needed
// after reset.
`default_nettype none

module set_assoc_lru_cache_lookup #(
   parameter int MAX_SETS   = 256,
   parameter int MAX_WAYS   = 8,
   parameter int ADDR_WIDTH = 32,
   localparam int SET_LIM   = $clog2(MAX_SETS + 1) - 1,
   localparam int SET_W     = (SET_LIM > 0) ? SET_LIM : 1,
   localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output      logic                  busy,
   input  wire logic [ADDR_WIDTH-1:0] req_address,
   input  wire logic                  req_func,
   output      logic                  rsp_strobe,
   output      logic [1:0]            rsp_outcome,
   output      logic [SET_W-1:0]      rsp_set_index,
   output      logic [31:0]           rsp_tag_value,
   output      logic [WAY_W-1:0]      rsp_way,
   output      logic [31:0]           rsp_old_tag,
   output      logic                  rsp_old_tag_valid,
   output      logic                  rsp_line_was_valid,
   output      logic                  rsp_line_was_dirty,
   output      logic [31:0]           rsp_last_used,
   output      logic [12:0]           rsp_bytes_read,
   output      logic [12:0]           rsp_bytes_written,
   output      logic [7:0]            rsp_cycles,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [3:0]            paddr,
   input  wire logic [31:0]           pwdata,
   output      logic [31:0]           prdata,
   output      logic                  pready
);
   import salc_pkg::*;

   localparam int FILL_W = $clog2(MAX_WAYS + 1);

   typedef struct packed {
      logic [MAX_WAYS-1:0]             valid;
      logic [MAX_WAYS-1:0]             dirty;
      logic [MAX_WAYS-1:0][31:0]       tag;
      logic [MAX_WAYS-1:0][31:0]       stamp;
      logic [MAX_WAYS-1:0][WAY_W-1:0]  rank;
      logic [FILL_W-1:0]               fill;
   } row_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   row_type mem [MAX_SETS];

   state_type           state_ff, state_in;
   logic [MAX_SETS-1:0] set_valid_ff;
   logic [3:0]          set_index_bits_ff, offset_bits_ff, ways_in_use_ff;
   logic [31:0]         access_counter_ff;

   row_type             row_ff;
   logic [SET_W-1:0]    set_ff;
   logic [31:0]         tag_ff;
   logic [31:0]         stamp_ff;
   logic                wr_ff;
   logic [3:0]          ob_ff;
   logic [WAY_W-1:0]    scan_ff;
   logic                hit_ff;
   logic [WAY_W-1:0]    hit_way_ff;
   logic [WAY_W-1:0]    victim_ff;

   logic                strobe_ff;
   logic [1:0]          outcome_ff;
   logic [SET_W-1:0]    set_out_ff;
   logic [31:0]         tag_out_ff, old_tag_ff, last_ff;
   logic [WAY_W-1:0]    way_ff;
   logic                old_valid_ff, was_valid_ff, was_dirty_ff;
   logic [12:0]         bread_ff, bwritten_ff;
   logic [7:0]          cycles_ff;

   // Effective configuration after saturation.
   logic [4:0]          ways_eff;
   logic [3:0]          ob_eff, sb_eff;
   logic [SET_W-1:0]    set_c;
   logic [31:0]         tag_c;
   logic                accept, cfg_write;

   always_comb begin
      if (ways_in_use_ff == 4'd0) begin
         ways_eff = 5'd1;
      end else if (5'(ways_in_use_ff) > 5'(MAX_WAYS)) begin
         ways_eff = 5'(MAX_WAYS);
      end else begin
         ways_eff = 5'(ways_in_use_ff);
      end
      ob_eff = (offset_bits_ff > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : offset_bits_ff;
      sb_eff = (set_index_bits_ff > 4'(SET_LIM)) ? 4'(SET_LIM) : set_index_bits_ff;
      set_c  = SET_W'(req_address >> ob_eff)
               & SET_W'(((SET_W + 1)'(1) << sb_eff) - (SET_W + 1)'(1));
      tag_c  = 32'(req_address >> (5'(ob_eff) + 5'(sb_eff)));
   end

   assign accept    = start && (state_ff == ST_IDLE);
   assign cfg_write = psel && penable && pwrite && pready;

   // Scan one way per cycle: first valid match is the hit, last rank-zero way is the victim.
   logic scan_match, scan_last;
   assign scan_match = row_ff.valid[scan_ff] && (row_ff.tag[scan_ff] == tag_ff);
   assign scan_last  = (5'(scan_ff) == (ways_eff - 5'd1));

   // Row update and result for the access being finished.
   row_type          new_row;
   logic [1:0]       res_outcome;
   logic [WAY_W-1:0] res_way, mru_way, old_rank;
   logic [FILL_W-1:0] count, mru_n;
   logic             do_mru;
   logic [31:0]      res_old_tag, res_last;
   logic             res_old_valid, res_was_dirty;
   logic [12:0]      block, res_bread, res_bwritten;
   logic [7:0]       res_cycles;

   always_comb begin
      new_row       = row_ff;
      count         = row_ff.fill;
      block         = 13'd1 << ob_ff;
      res_outcome   = OUTCOME_HIT;
      res_way       = hit_way_ff;
      res_old_tag   = 32'd0;
      res_old_valid = 1'b0;
      res_was_dirty = 1'b0;
      res_last      = 32'd0;
      res_bread     = 13'd0;
      res_bwritten  = 13'd0;
      res_cycles    = HIT_CYCLES;
      do_mru        = 1'b0;
      mru_way       = hit_way_ff;
      mru_n         = count;
      if (hit_ff) begin
         res_old_tag   = tag_ff;
         res_old_valid = 1'b1;
         res_was_dirty = row_ff.dirty[hit_way_ff];
         res_last      = row_ff.stamp[hit_way_ff];
         new_row.stamp[hit_way_ff] = stamp_ff;
         if (wr_ff) begin
            new_row.dirty[hit_way_ff] = 1'b1;
         end
         do_mru = 1'b1;
      end else begin
         res_bread  = block;
         res_cycles = HIT_CYCLES + MISS_PENALTY;
         if (5'(count) >= ways_eff) begin
            res_way       = victim_ff;
            res_old_tag   = row_ff.tag[victim_ff];
            res_old_valid = 1'b1;
            res_was_dirty = row_ff.dirty[victim_ff];
            res_last      = row_ff.stamp[victim_ff];
            res_outcome   = OUTCOME_CLEAN_MISS;
            if (res_was_dirty) begin
               res_outcome  = OUTCOME_DIRTY_MISS;
               res_bwritten = block;
               res_cycles   = HIT_CYCLES + MISS_PENALTY + MISS_PENALTY;
            end
            do_mru  = 1'b1;
            mru_way = victim_ff;
            mru_n   = FILL_W'(ways_eff);
         end else begin
            res_outcome           = OUTCOME_CLEAN_MISS;
            res_way               = WAY_W'(count);
            new_row.rank[res_way] = WAY_W'(count);
            new_row.fill          = count + FILL_W'(1);
         end
         new_row.valid[res_way] = 1'b1;
         new_row.dirty[res_way] = wr_ff;
         new_row.tag[res_way]   = tag_ff;
         new_row.stamp[res_way] = stamp_ff;
      end
      old_rank = row_ff.rank[mru_way];
      if (do_mru) begin
         for (int k = 0; k < MAX_WAYS; k++) begin
            if ((k < int'(mru_n)) && (row_ff.rank[k] > old_rank)) begin
               new_row.rank[k] = row_ff.rank[k] - WAY_W'(1);
            end
         end
         new_row.rank[mru_way] = WAY_W'(mru_n - FILL_W'(1));
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start) state_in = ST_READ;
         ST_READ:   state_in = ST_SCAN;
         ST_SCAN:   if (scan_last) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         row_ff <= set_valid_ff[set_ff] ? mem[set_ff] : '0;
      end
      if (state_ff == ST_UPDATE) begin
         mem[set_ff] <= new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         set_valid_ff      <= '0;
         set_index_bits_ff <= RESET_SET_INDEX_BITS;
         offset_bits_ff    <= RESET_OFFSET_BITS;
         ways_in_use_ff    <= RESET_WAYS_IN_USE;
         access_counter_ff <= 32'd0;
         strobe_ff         <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= (state_ff == ST_UPDATE);
         if (cfg_write && (paddr[3:2] != 2'd3)) begin
            set_valid_ff <= '0;
            unique case (csr_index_type'(paddr[3:2]))
               CSR_SET_INDEX_BITS: set_index_bits_ff <= pwdata[3:0];
               CSR_OFFSET_BITS:    offset_bits_ff    <= pwdata[3:0];
               CSR_WAYS_IN_USE:    ways_in_use_ff    <= pwdata[3:0];
               default:            ;
            endcase
         end
         if (accept) begin
            set_ff            <= set_c;
            tag_ff            <= tag_c;
            stamp_ff          <= access_counter_ff;
            access_counter_ff <= access_counter_ff + 32'd1;
            wr_ff             <= req_func;
            ob_ff             <= ob_eff;
         end
         if (state_ff == ST_READ) begin
            scan_ff   <= '0;
            hit_ff    <= 1'b0;
            victim_ff <= '0;
         end
         if (state_ff == ST_SCAN) begin
            scan_ff <= scan_ff + WAY_W'(1);
            if (!hit_ff && scan_match) begin
               hit_ff     <= 1'b1;
               hit_way_ff <= scan_ff;
            end
            if (row_ff.rank[scan_ff] == '0) begin
               victim_ff <= scan_ff;
            end
         end
         if (state_ff == ST_UPDATE) begin
            set_valid_ff[set_ff] <= 1'b1;
            outcome_ff   <= res_outcome;
            set_out_ff   <= set_ff;
            tag_out_ff   <= tag_ff;
            way_ff       <= res_way;
            old_tag_ff   <= res_old_tag;
            old_valid_ff <= res_old_valid;
            was_valid_ff <= res_old_valid;
            was_dirty_ff <= res_was_dirty;
            last_ff      <= res_last;
            bread_ff     <= res_bread;
            bwritten_ff  <= res_bwritten;
            cycles_ff    <= res_cycles;
         end
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         CSR_SET_INDEX_BITS: prdata = {28'd0, set_index_bits_ff};
         CSR_OFFSET_BITS:    prdata = {28'd0, offset_bits_ff};
         CSR_WAYS_IN_USE:    prdata = {28'd0, ways_in_use_ff};
         default:            prdata = 32'd0;
      endcase
   end

   assign pready             = 1'b1;
   assign busy               = (state_ff != ST_IDLE);
   assign rsp_strobe         = strobe_ff;
   assign rsp_outcome        = outcome_ff;
   assign rsp_set_index      = set_out_ff;
   assign rsp_tag_value      = tag_out_ff;
   assign rsp_way            = way_ff;
   assign rsp_old_tag        = old_tag_ff;
   assign rsp_old_tag_valid  = old_valid_ff;
   assign rsp_line_was_valid = was_valid_ff;
   assign rsp_line_was_dirty = was_dirty_ff;
   assign rsp_last_used      = last_ff;
   assign rsp_bytes_read     = bread_ff;
   assign rsp_bytes_written  = bwritten_ff;
   assign rsp_cycles         = cycles_ff;

endmodule

`default_nettype wire

// File: rtl/core/salc_checker.sv
// Port-level checker for the cache lookup block, bound to the top level.
// Depends on salc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module salc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_strobe,
   input wire logic [1:0]  rsp_outcome,
   input wire logic [12:0] rsp_bytes_read,
   input wire logic [12:0] rsp_bytes_written,
   input wire logic [7:0]  rsp_cycles
);
   import salc_pkg::*;

   `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
   `ASSERT_SAME(a_strobe_idle, rsp_strobe, !busy, "result beat while still busy")
   `ASSERT_NEXT(a_single_beat, rsp_strobe, !rsp_strobe, "one access gave two result beats")
   `ASSERT_SAME(a_hit_cost, rsp_strobe && (rsp_outcome == OUTCOME_HIT),
      (rsp_cycles == HIT_CYCLES) && (rsp_bytes_read == 13'd0), "hit with miss cost")
   `ASSERT_SAME(a_dirty_cost, rsp_strobe && (rsp_outcome == OUTCOME_DIRTY_MISS),
      rsp_bytes_written == rsp_bytes_read, "write-back size differs from fill size")

endmodule

bind set_assoc_lru_cache_lookup salc_checker u_salc_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_strobe        (rsp_strobe),
   .rsp_outcome       (rsp_outcome),
   .rsp_bytes_read    (rsp_bytes_read),
   .rsp_bytes_written (rsp_bytes_written),
   .rsp_cycles        (rsp_cycles)
);

`default_nettype wire
